// ===== sv/swm_pkg.sv =====
// Shared types and constants for the sliding window maximum unit.
// No dependencies; compiled first.
package swm_pkg;

  // Window size register, width and value after reset.
  localparam int          CFG_W     = 7;
  localparam logic [6:0]  WIN_RESET = 7'd8;

  // What every cell of the deque does in a cycle.
  typedef enum logic [1:0] {
    OP_HOLD,   // keep contents
    OP_SHIFT,  // drop one expired front entry, take right neighbor
    OP_STEP    // take one sample: front pop, back pops, append
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     clear;  // stream start: treat all entries as empty
  } cell_ctrl_t;

endpackage

// ===== sv/swm_ifs.sv =====
// Valid/ready channel interfaces of the sliding window maximum unit.
// Sample channel and result channel; no dependencies.
interface swm_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           stream_start;

  modport source (output valid, sample, stream_start, input ready);
  modport sink   (input valid, sample, stream_start, output ready);
endinterface

interface swm_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] window_max;

  modport source (output valid, window_max, input ready);
  modport sink   (input valid, window_max, output ready);
endinterface

// ===== sv/swm_cell.sv =====
// One deque cell: a candidate value with its stream position.
// Depends on swm_pkg.
module swm_cell #(
  parameter int SW = 16,
  parameter int PW = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  swm_pkg::cell_ctrl_t    ctrl_i,
  input  logic                   pop_i,
  input  logic signed [SW-1:0]   x_i,
  input  logic [PW-1:0]          p_i,
  input  logic                   nxt_valid_i,
  input  logic signed [SW-1:0]   nxt_val_i,
  input  logic [PW-1:0]          nxt_pos_i,
  input  logic                   prv_keep_i,
  output logic                   valid_o,
  output logic signed [SW-1:0]   val_o,
  output logic [PW-1:0]          pos_o,
  output logic                   keep_o
);
  import swm_pkg::*;

  logic                 valid_q, valid_d;
  logic signed [SW-1:0] val_q, val_d;
  logic [PW-1:0]        pos_q, pos_d;
  logic                 src_valid;
  logic signed [SW-1:0] src_val;
  logic [PW-1:0]        src_pos;
  logic                 keep;

  // Source after an optional front pop; entries not above x are dropped.
  assign src_valid = (pop_i ? nxt_valid_i : valid_q) & ~ctrl_i.clear;
  assign src_val   = pop_i ? nxt_val_i : val_q;
  assign src_pos   = pop_i ? nxt_pos_i : pos_q;
  assign keep      = src_valid && (src_val > x_i);

  always_comb begin
    valid_d = valid_q;
    val_d   = val_q;
    pos_d   = pos_q;
    case (ctrl_i.op)
      OP_SHIFT: begin
        valid_d = nxt_valid_i;
        val_d   = nxt_val_i;
        pos_d   = nxt_pos_i;
      end
      OP_STEP: begin
        if (keep) begin
          valid_d = 1'b1;
          val_d   = src_val;
          pos_d   = src_pos;
        end else if (prv_keep_i) begin
          // first free slot takes the new sample
          valid_d = 1'b1;
          val_d   = x_i;
          pos_d   = p_i;
        end else begin
          valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    pos_q <= pos_d;
  end

  assign valid_o = valid_q;
  assign val_o   = val_q;
  assign pos_o   = pos_q;
  assign keep_o  = keep;

endmodule

// ===== sv/sliding_window_maximum_unit.sv =====
// Sliding window maximum unit: top level. Uses swm_pkg, swm_ifs and swm_cell.
// Holds the deque as a row of MAX_WINDOW cells plus counters and the result register.
//
// Takes one signed sample per cycle and, once window_size samples have been
// seen since the last stream start, returns the largest of the last
// window_size samples for every sample. The candidates sit in a row of cells,
// oldest at cell 0, values strictly falling toward the back. Each sample is
// compared against all cells at once: the cells not above it drop out, the
// front cell leaves when its position falls out of the window, and the
// sample lands in the first free cell, all in the accept cycle. Steady rate
// is one word per clock while the output register, in which results wait,
// is empty or being read. After window_size is lowered, a sample may find
// several front entries out of the window; each one beyond the first is
// cleared by a shift of the row by one cell, in which no word is accepted.
// window_size is written through cfg_we_i/cfg_wdata_i; the user must write
// it only while the unit is idle, as the block does not enforce it. 0 acts
// as 1 and values above MAX_WINDOW act as MAX_WINDOW.
module sliding_window_maximum_unit #(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [swm_pkg::CFG_W-1:0] cfg_wdata_i,
  swm_in_if.sink                    smp_i,
  swm_out_if.source                 max_o
);
  import swm_pkg::*;

  localparam int POS_MOD = 2 * MAX_WINDOW;
  localparam int PW      = $clog2(POS_MOD);        // position width
  localparam int WW      = $clog2(MAX_WINDOW + 1); // window/count width
  localparam int CW      = (CFG_W > WW) ? CFG_W : WW;
  localparam int SW      = SAMPLE_WIDTH;

  // Age of an entry at position pos seen from position p, modulo POS_MOD.
  function automatic logic [PW-1:0] age_of(input logic [PW-1:0] p,
                                            input logic [PW-1:0] pos);
    logic [PW:0] acc;
    acc = {1'b0, p} - {1'b0, pos};
    if (p < pos) begin
      acc = acc + (PW+1)'(POS_MOD);
    end
    return acc[PW-1:0];
  endfunction

  // Configuration
  logic [CFG_W-1:0] win_q;
  logic [CW-1:0]    win_ext;
  logic [WW-1:0]    w_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_RESET;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  assign win_ext = CW'(win_q);
  always_comb begin
    if (win_ext == '0) begin
      w_eff = WW'(1);
    end else if (win_ext > CW'(MAX_WINDOW)) begin
      w_eff = WW'(MAX_WINDOW);
    end else begin
      w_eff = win_ext[WW-1:0];
    end
  end

  // Counters
  logic [PW-1:0] pos_q, pos_d;
  logic [WW-1:0] seen_q, seen_d;
  logic [PW-1:0] p_step;
  logic [WW-1:0] seen_base;
  logic [WW:0]   seen_inc;
  logic          full_win;

  // Cell row
  logic                 cv   [MAX_WINDOW];
  logic signed [SW-1:0] cval [MAX_WINDOW];
  logic [PW-1:0]        cpos [MAX_WINDOW];
  logic                 ckeep[MAX_WINDOW];
  cell_ctrl_t           ctrl;
  logic                 pop;
  logic                 need_clean;
  logic                 accept;

  // Result register
  logic                 out_valid_q, out_valid_d;
  logic signed [SW-1:0] out_data_q, out_data_d;
  logic signed [SW-1:0] front_val;

  assign p_step    = smp_i.stream_start ? '0 : pos_q;
  assign seen_base = smp_i.stream_start ? '0 : seen_q;
  assign seen_inc  = {1'b0, seen_base} + (WW+1)'(1);
  assign full_win  = seen_inc >= {1'b0, w_eff};

  // More than one front entry out of the window: shift first.
  assign need_clean = cv[0] && cv[1] &&
                      (age_of(pos_q, cpos[1]) >= PW'(w_eff));

  assign smp_i.ready = !need_clean && (!out_valid_q || max_o.ready);
  assign accept      = smp_i.valid && smp_i.ready;

  // Single front pop within the step
  assign pop = !smp_i.stream_start && cv[0] &&
               (age_of(p_step, cpos[0]) >= PW'(w_eff));

  always_comb begin
    ctrl.clear = smp_i.stream_start;
    if (accept) begin
      ctrl.op = OP_STEP;
    end else if (need_clean && smp_i.valid) begin
      ctrl.op = OP_SHIFT;
    end else begin
      ctrl.op = OP_HOLD;
    end
  end

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic                 nxt_valid;
    logic signed [SW-1:0] nxt_val;
    logic [PW-1:0]        nxt_pos;
    logic                 prv_keep;

    if (i == MAX_WINDOW - 1) begin : g_last
      assign nxt_valid = 1'b0;
      assign nxt_val   = '0;
      assign nxt_pos   = '0;
    end else begin : g_mid
      assign nxt_valid = cv[i+1];
      assign nxt_val   = cval[i+1];
      assign nxt_pos   = cpos[i+1];
    end

    if (i == 0) begin : g_first
      assign prv_keep = 1'b1;
    end else begin : g_rest
      assign prv_keep = ckeep[i-1];
    end

    swm_cell #(
      .SW (SW),
      .PW (PW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .pop_i       (pop),
      .x_i         (smp_i.sample),
      .p_i         (p_step),
      .nxt_valid_i (nxt_valid),
      .nxt_val_i   (nxt_val),
      .nxt_pos_i   (nxt_pos),
      .prv_keep_i  (prv_keep),
      .valid_o     (cv[i]),
      .val_o       (cval[i]),
      .pos_o       (cpos[i]),
      .keep_o      (ckeep[i])
    );
  end

  // New front after the step: surviving source of cell 0, else the sample.
  assign front_val = ckeep[0] ? (pop ? cval[1] : cval[0]) : smp_i.sample;

  always_comb begin
    pos_d       = pos_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && max_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      pos_d  = (p_step == PW'(POS_MOD - 1)) ? '0 : p_step + PW'(1);
      seen_d = full_win ? w_eff : seen_inc[WW-1:0];
      if (full_win) begin
        out_valid_d = 1'b1;
        out_data_d  = front_val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign max_o.valid      = out_valid_q;
  assign max_o.window_max = out_data_q;

endmodule
